[hw/rtl/oaie_pkg.sv]
// Shared types and constants for the ordered array insert/erase block.
package oaie_pkg;

  // Number of entry slots and the widths fixed by the item fields
  localparam int CAPACITY = 16;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_ERASE  = 3'd1,
    KIND_PUSH   = 3'd2,
    KIND_POP    = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DONE = 2'd2
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // capture the incoming item
    logic execute;  // apply the captured request and register the result
  } cmd_t;

endpackage

[hw/rtl/oaie_ctrl.sv]
// Controller state machine: sequences capture, execute and result handoff.
module oaie_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_ready,
  output logic           in_ready,
  output logic           out_valid,
  output oaie_pkg::cmd_t cmd
);

  oaie_pkg::state_t state;
  oaie_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oaie_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      oaie_pkg::S_IDLE: begin
        if (in_valid) state_next = oaie_pkg::S_EXEC;
      end
      oaie_pkg::S_EXEC: begin
        state_next = oaie_pkg::S_DONE;
      end
      oaie_pkg::S_DONE: begin
        if (out_ready) state_next = oaie_pkg::S_IDLE;
      end
      default: begin
        state_next = oaie_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      oaie_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      oaie_pkg::S_EXEC: begin
        cmd.execute = 1'b1;
      end
      oaie_pkg::S_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/oaie_datapath.sv]
// Datapath: entry cells, fill count, request and result registers.
module oaie_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  oaie_pkg::cmd_t                    cmd,
  input  logic [oaie_pkg::KIND_W-1:0]       kind,
  input  logic [oaie_pkg::IDX_W-1:0]        position,
  input  logic signed [oaie_pkg::DATA_W-1:0] data_in,
  output logic [oaie_pkg::STAT_W-1:0]       status,
  output logic [oaie_pkg::CNT_W-1:0]        fill_count,
  output logic signed [oaie_pkg::DATA_W-1:0] data_out
);

  // Captured request
  logic [oaie_pkg::KIND_W-1:0] req_kind;
  logic [oaie_pkg::IDX_W-1:0]  req_pos;
  logic [oaie_pkg::DATA_W-1:0] req_data;

  // Array state
  logic [oaie_pkg::DATA_W-1:0] entries      [oaie_pkg::CAPACITY];
  logic [oaie_pkg::DATA_W-1:0] entries_next [oaie_pkg::CAPACITY];
  logic [oaie_pkg::CNT_W-1:0]  count;
  logic [oaie_pkg::CNT_W-1:0]  count_next;

  // Decoded operation
  logic                        is_full;
  logic                        is_empty;
  logic                        pos_le_count;
  logic                        pos_lt_count;
  logic                        do_insert;
  logic                        do_erase;
  logic                        do_push;
  logic                        do_read;
  oaie_pkg::status_t           stat_next;
  logic [oaie_pkg::CNT_W-1:0]  pos_ext;

  assign pos_ext      = oaie_pkg::CNT_W'(req_pos);
  assign is_full      = (count >= oaie_pkg::CNT_W'(oaie_pkg::CAPACITY));
  assign is_empty     = (count == '0);
  assign pos_le_count = (pos_ext <= count);
  assign pos_lt_count = (pos_ext < count);

  // Request decode and status
  always_comb begin
    do_insert  = 1'b0;
    do_erase   = 1'b0;
    do_push    = 1'b0;
    do_read    = 1'b0;
    stat_next  = oaie_pkg::STAT_OK;
    count_next = count;
    unique case (oaie_pkg::kind_t'(req_kind))
      oaie_pkg::KIND_INSERT: begin
        if (is_full) begin
          stat_next = oaie_pkg::STAT_FULL;
        end else if (!pos_le_count) begin
          stat_next = oaie_pkg::STAT_INVALID;
        end else begin
          do_insert  = 1'b1;
          count_next = count + 1'b1;
        end
      end
      oaie_pkg::KIND_ERASE: begin
        if (!pos_lt_count) begin
          stat_next = oaie_pkg::STAT_INVALID;
        end else begin
          do_erase   = 1'b1;
          count_next = count - 1'b1;
        end
      end
      oaie_pkg::KIND_PUSH: begin
        if (is_full) begin
          stat_next = oaie_pkg::STAT_FULL;
        end else begin
          do_push    = 1'b1;
          count_next = count + 1'b1;
        end
      end
      oaie_pkg::KIND_POP: begin
        if (is_empty) begin
          stat_next = oaie_pkg::STAT_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      oaie_pkg::KIND_READ: begin
        if (!pos_lt_count) begin
          stat_next = oaie_pkg::STAT_INVALID;
        end else begin
          do_read = 1'b1;
        end
      end
      default: begin
        stat_next = oaie_pkg::STAT_INVALID;
      end
    endcase
  end

  // Per-cell update: each cell picks its own, its lower or upper neighbor,
  // or the new value. Cells above the count may take junk; never read.
  always_comb begin
    for (int k = 0; k < oaie_pkg::CAPACITY; k++) begin
      entries_next[k] = entries[k];
      if (do_insert) begin
        if (oaie_pkg::IDX_W'(k) == req_pos) begin
          entries_next[k] = req_data;
        end else if (oaie_pkg::IDX_W'(k) > req_pos) begin
          entries_next[k] = entries[(k > 0) ? k - 1 : 0];
        end
      end else if (do_erase) begin
        if (oaie_pkg::IDX_W'(k) >= req_pos && k < oaie_pkg::CAPACITY - 1) begin
          entries_next[k] = entries[(k < oaie_pkg::CAPACITY - 1) ? k + 1 : k];
        end
      end else if (do_push) begin
        if (oaie_pkg::CNT_W'(k) == count) begin
          entries_next[k] = req_data;
        end
      end
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= kind;
      req_pos  <= position;
      req_data <= data_in;
    end
  end

  // Entry cells
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int k = 0; k < oaie_pkg::CAPACITY; k++) begin
        entries[k] <= entries_next[k];
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status     <= stat_next;
      fill_count <= count_next;
      data_out   <= do_read ? entries[req_pos] : '0;
    end
  end

endmodule

[hw/rtl/ordered_array_insert_erase.sv]
// Top level: fixed-capacity ordered array with insert, erase, push, pop, read.
//
// Input channel (in_valid/in_ready) carries one request item: kind,
// position and data_in. Output channel (out_valid/out_ready) returns one
// result item per request: status, fill_count after the request, and
// data_out (the entry for a successful read, otherwise zero).
// One request is in flight at a time. A request is captured at the accepting
// edge, executed in the next cycle (all cells shift in parallel), and its
// result is offered on the cycle after that. in_ready returns only after
// the result is taken, so no new item is accepted until the capture /
// execute / deliver sequence of the controller has run to its end.
// While the receiver stalls, the result is held steady and no new item is
// accepted. Synchronous reset (rst) empties the array: the fill count goes
// to zero and the controller returns to idle. Entry contents are not
// cleared; only entries below the fill count are ever returned.
module ordered_array_insert_erase (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [oaie_pkg::KIND_W-1:0]        kind,
  input  logic [oaie_pkg::IDX_W-1:0]         position,
  input  logic signed [oaie_pkg::DATA_W-1:0] data_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [oaie_pkg::STAT_W-1:0]        status,
  output logic [oaie_pkg::CNT_W-1:0]         fill_count,
  output logic signed [oaie_pkg::DATA_W-1:0] data_out
);

  oaie_pkg::cmd_t cmd;

  oaie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  oaie_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .kind       (kind),
    .position   (position),
    .data_in    (data_in),
    .status     (status),
    .fill_count (fill_count),
    .data_out   (data_out)
  );

  // One item at a time: never ready for input while a result is offered
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // Fill count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_count <= oaie_pkg::CNT_W'(oaie_pkg::CAPACITY)))
    else $error("fill count above capacity");

  // Nonzero read data only comes with an ok status
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && data_out != '0) |-> (status == oaie_pkg::STAT_OK))
    else $error("read data on failed request");

  // An accepted item closes the input side on the next cycle
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready after accept");

endmodule

[bench/tb.sv]
// Testbench for the ordered array block: directed and random requests vs a shadow array.
`timescale 1ns / 1ps

module tb;
  import oaie_pkg::*;

  // Kind codes outside the defined set
  localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    status_t                  st;
    logic [CNT_W-1:0]         cnt;
    logic signed [DATA_W-1:0] rd;
  } outcome_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [KIND_W-1:0]        kind;
  logic [IDX_W-1:0]         position;
  logic signed [DATA_W-1:0] data_in;
  logic                     out_valid;
  logic                     out_ready;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         fill_count;
  logic signed [DATA_W-1:0] data_out;

  // Shadow copy of the array and its fill count
  logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
  int                       shadow_count;
  outcome_t                 expected_results [$];

  int errors;
  int items_sent;
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_left;
  int idle_cycles;

  ordered_array_insert_erase dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .position   (position),
    .data_in    (data_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .fill_count (fill_count),
    .data_out   (data_out)
  );

  always #1 clk = ~clk;

  // Apply one accepted request to the shadow array and queue its result
  task automatic predict_request(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] p,
                                 input logic signed [DATA_W-1:0] d);
    outcome_t r;
    int       pos;
    int       i;
    pos  = int'(p);
    r.st = STAT_OK;
    r.rd = '0;
    case (k)
      KIND_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.st = STAT_FULL;
        end else if (pos > shadow_count) begin
          r.st = STAT_INVALID;
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos] = d;
          shadow_count++;
        end
      end
      KIND_ERASE: begin
        if (pos >= shadow_count) begin
          r.st = STAT_INVALID;
        end else begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      KIND_PUSH: begin
        if (shadow_count >= CAPACITY) begin
          r.st = STAT_FULL;
        end else begin
          shadow_entries[shadow_count] = d;
          shadow_count++;
        end
      end
      KIND_POP: begin
        if (shadow_count == 0) r.st = STAT_EMPTY;
        else shadow_count--;
      end
      KIND_READ: begin
        if (pos >= shadow_count) r.st = STAT_INVALID;
        else r.rd = shadow_entries[pos];
      end
      default: r.st = STAT_INVALID;
    endcase
    r.cnt = shadow_count[CNT_W-1:0];
    expected_results.insert(expected_results.size(), r);
  endtask

  // Offer one item, with random idle cycles ahead of it, and wait until accepted
  task automatic issue_request(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] p,
                               input logic signed [DATA_W-1:0] d);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    position <= p;
    data_in  <= d;
    do @(posedge clk); while (!in_ready);
    predict_request(k, p, d);
    items_sent++;
  endtask

  // One request of a random kind, mostly aimed at valid positions
  task automatic issue_mixed_request();
    logic [KIND_W-1:0] k;
    logic [IDX_W-1:0]  p;
    int                top;
    if ($urandom_range(0, 9) == 0) begin
      k = KIND_W'($urandom_range(KIND_INSERT, KIND_UNUSED_LAST));
      p = IDX_W'($urandom_range(0, 15));
    end else begin
      k = KIND_W'($urandom_range(KIND_INSERT, KIND_READ));
      p = IDX_W'($urandom_range(0, 15));
      if ($urandom_range(0, 99) >= 15) begin
        if (k == KIND_INSERT) begin
          top = (shadow_count > 15) ? 15 : shadow_count;
          p = IDX_W'($urandom_range(0, top));
        end else if (shadow_count > 0) begin
          p = IDX_W'($urandom_range(0, shadow_count - 1));
        end
      end
    end
    issue_request(k, p, $urandom());
  endtask

  // Grow the array to capacity, then try to add past it and read one entry
  task automatic fill_burst();
    while (shadow_count < CAPACITY) begin
      if ($urandom_range(0, 1) == 0) begin
        issue_request(KIND_PUSH, IDX_W'($urandom_range(0, 15)), $urandom());
      end else begin
        issue_request(KIND_INSERT, IDX_W'($urandom_range(0, shadow_count)), $urandom());
      end
    end
    issue_request(KIND_INSERT, IDX_W'($urandom_range(0, 15)), $urandom());
    issue_request(KIND_PUSH, IDX_W'($urandom_range(0, 15)), $urandom());
    issue_request(KIND_READ, IDX_W'($urandom_range(0, 15)), $urandom());
  endtask

  // Shrink the array to empty, then poke at the empty state
  task automatic drain_burst();
    while (shadow_count > 0) begin
      if ($urandom_range(0, 1) == 0) begin
        issue_request(KIND_POP, IDX_W'($urandom_range(0, 15)), $urandom());
      end else begin
        issue_request(KIND_ERASE, IDX_W'($urandom_range(0, shadow_count - 1)), $urandom());
      end
    end
    issue_request(KIND_POP, IDX_W'($urandom_range(0, 15)), $urandom());
    issue_request(KIND_ERASE, IDX_W'($urandom_range(0, 15)), $urandom());
    issue_request(KIND_READ, IDX_W'($urandom_range(0, 15)), $urandom());
  endtask

  // Empty-array cases, every kind and the field extremes
  task automatic test_directed_requests();
    int k;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    issue_request(KIND_READ, 4'd0, 32'sd0);
    issue_request(KIND_ERASE, 4'd0, 32'sd0);
    issue_request(KIND_POP, 4'd0, 32'sd0);
    issue_request(KIND_INSERT, 4'd1, 32'sd7);
    issue_request(KIND_INSERT, 4'd0, 32'h8000_0000);
    issue_request(KIND_PUSH, 4'd15, 32'h7fff_ffff);
    issue_request(KIND_INSERT, 4'd1, -32'sd1);
    issue_request(KIND_INSERT, 4'd3, 32'sd0);
    issue_request(KIND_INSERT, 4'd0, 32'h5555_5555);
    issue_request(KIND_INSERT, 4'd15, 32'haaaa_aaaa);
    for (k = int'(KIND_UNUSED_FIRST); k <= int'(KIND_UNUSED_LAST); k++) begin
      issue_request(KIND_W'(k), 4'd0, 32'sd1);
    end
    issue_request(KIND_READ, 4'd0, 32'sd0);
    issue_request(KIND_READ, 4'd4, 32'sd0);
    issue_request(KIND_READ, 4'd5, 32'sd0);
    issue_request(KIND_ERASE, 4'd2, 32'sd0);
    issue_request(KIND_ERASE, 4'd0, 32'sd0);
    issue_request(KIND_READ, 4'd0, 32'sd0);
    issue_request(KIND_POP, 4'd0, 32'sd0);
    issue_request(KIND_ERASE, 4'd15, 32'sd0);
    issue_request(KIND_READ, 4'd15, 32'sd0);
  endtask

  // Random traffic: fill and drain runs mixed with single random requests
  task automatic test_random_requests(input int n, input int idle_pct, input int stall_pct);
    int target;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    target = items_sent + n;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0: fill_burst();
        1: drain_burst();
        default: issue_mixed_request();
      endcase
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_receiver_backpressure();
    int i;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    for (i = 0; i < 12; i++) issue_mixed_request();
  endtask

  // Receiver: random stalls, or a long hold when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d count %0d data %0d",
                 $time, status, fill_count, data_out);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.st) begin
          $display("%0t: status mismatch: expected %0d actual %0d", $time, want.st, status);
          errors++;
        end
        if (fill_count !== want.cnt) begin
          $display("%0t: fill_count mismatch: expected %0d actual %0d",
                   $time, want.cnt, fill_count);
          errors++;
        end
        if (data_out !== want.rd) begin
          $display("%0t: data_out mismatch: expected %0d actual %0d", $time, want.rd, data_out);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any item moving ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst                = 1'b1;
    in_valid           = 1'b0;
    kind               = KIND_INSERT;
    position           = '0;
    data_in            = '0;
    out_ready          = 1'b0;
    errors             = 0;
    items_sent         = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_left          = 0;
    idle_cycles        = 0;
    shadow_count       = 0;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_requests();
    test_random_requests(380, 19, 54);
    test_receiver_backpressure();
    test_random_requests(380, 54, 19);
    test_random_requests(380, 0, 0);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
